### sv/lz77_token_decoder_top_defines.svh
// assertion macros for the lz77 token decoder
// included by the modules that carry concurrent checks; no other dependencies
`ifndef LZ77_TOKEN_DECODER_TOP_DEFINES_SVH
`define LZ77_TOKEN_DECODER_TOP_DEFINES_SVH

// clocked check, disabled while reset is held
`define LZTD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// clocked check that a condition never holds
`define LZTD_NEVER(label, expr, msg) \
    `LZTD_ASSERT(label, !(expr), msg)

`endif

### sv/lz77td_pkg.sv
// shared types, constants and code tables of the lz77 token decoder
// no dependencies; used by lz77_token_decoder_top
package lz77td_pkg;

    localparam int WIN_DEPTH = 32768;
    localparam int WIN_AW    = $clog2(WIN_DEPTH);
    localparam int BYTE_W    = 8;
    localparam int BPR       = 8;
    localparam int BPR_AW    = $clog2(BPR);
    localparam int OUT_W     = BPR * BYTE_W;
    localparam int CNT_W     = 4;
    localparam int SYM_W     = 9;
    localparam int LEN_W     = 9;
    localparam int LX_W      = 5;
    localparam int DC_W      = 5;
    localparam int DX_W      = 13;
    localparam int S_DATA_W  = 32;
    localparam int M_DATA_W  = 72;

    localparam logic [SYM_W-1:0] SYM_EOB       = 9'd284;
    localparam logic [SYM_W-1:0] SYM_LIT_LIMIT = 9'd256;
    localparam logic [DC_W-1:0]  LEN_CODE_MAX  = 5'd27;
    localparam logic [DC_W-1:0]  DIST_CODE_MAX = 5'd29;
    localparam logic [LEN_W-1:0] MIN_MATCH     = 9'd3;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_READ,
        ST_WRITE
    } state_t;

    // length code base
    function automatic logic [7:0] len_base(input logic [DC_W-1:0] code_in);
        logic [DC_W-1:0] code;
        logic [7:0]      base;
        code = (code_in > LEN_CODE_MAX) ? LEN_CODE_MAX : code_in;
        case (code)
            5'd0:  base = 8'd0;
            5'd1:  base = 8'd1;
            5'd2:  base = 8'd2;
            5'd3:  base = 8'd3;
            5'd4:  base = 8'd4;
            5'd5:  base = 8'd5;
            5'd6:  base = 8'd6;
            5'd7:  base = 8'd7;
            5'd8:  base = 8'd8;
            5'd9:  base = 8'd10;
            5'd10: base = 8'd12;
            5'd11: base = 8'd14;
            5'd12: base = 8'd16;
            5'd13: base = 8'd20;
            5'd14: base = 8'd24;
            5'd15: base = 8'd28;
            5'd16: base = 8'd32;
            5'd17: base = 8'd40;
            5'd18: base = 8'd48;
            5'd19: base = 8'd56;
            5'd20: base = 8'd64;
            5'd21: base = 8'd80;
            5'd22: base = 8'd96;
            5'd23: base = 8'd112;
            5'd24: base = 8'd128;
            5'd25: base = 8'd160;
            5'd26: base = 8'd192;
            default: base = 8'd224;
        endcase
        return base;
    endfunction

    // mask of the extra bits a length code uses
    function automatic logic [LX_W-1:0] len_mask(input logic [DC_W-1:0] code_in);
        logic [DC_W-1:0] code;
        logic [LX_W-1:0] mask;
        code = (code_in > LEN_CODE_MAX) ? LEN_CODE_MAX : code_in;
        if (code < 5'd8) begin
            mask = 5'h00;
        end else if (code < 5'd12) begin
            mask = 5'h01;
        end else if (code < 5'd16) begin
            mask = 5'h03;
        end else if (code < 5'd20) begin
            mask = 5'h07;
        end else if (code < 5'd24) begin
            mask = 5'h0f;
        end else begin
            mask = 5'h1f;
        end
        return mask;
    endfunction

    // distance code base
    function automatic logic [WIN_AW-1:0] dist_base(input logic [DC_W-1:0] code_in);
        logic [DC_W-1:0]   code;
        logic [WIN_AW-1:0] base;
        code = (code_in > DIST_CODE_MAX) ? DIST_CODE_MAX : code_in;
        case (code)
            5'd0:  base = 15'd0;
            5'd1:  base = 15'd1;
            5'd2:  base = 15'd2;
            5'd3:  base = 15'd3;
            5'd4:  base = 15'd4;
            5'd5:  base = 15'd6;
            5'd6:  base = 15'd8;
            5'd7:  base = 15'd12;
            5'd8:  base = 15'd16;
            5'd9:  base = 15'd24;
            5'd10: base = 15'd32;
            5'd11: base = 15'd48;
            5'd12: base = 15'd64;
            5'd13: base = 15'd96;
            5'd14: base = 15'd128;
            5'd15: base = 15'd192;
            5'd16: base = 15'd256;
            5'd17: base = 15'd384;
            5'd18: base = 15'd512;
            5'd19: base = 15'd768;
            5'd20: base = 15'd1024;
            5'd21: base = 15'd1536;
            5'd22: base = 15'd2048;
            5'd23: base = 15'd3072;
            5'd24: base = 15'd4096;
            5'd25: base = 15'd6144;
            5'd26: base = 15'd8192;
            5'd27: base = 15'd12288;
            5'd28: base = 15'd16384;
            default: base = 15'd24576;
        endcase
        return base;
    endfunction

    // mask of the extra bits a distance code uses
    function automatic logic [DX_W-1:0] dist_mask(input logic [DC_W-1:0] code_in);
        logic [DC_W-1:0] code;
        logic [DX_W-1:0] mask;
        code = (code_in > DIST_CODE_MAX) ? DIST_CODE_MAX : code_in;
        if (code < 5'd4) begin
            mask = '0;
        end else begin
            mask = DX_W'((14'd1 << ((code >> 1) - 5'd1)) - 14'd1);
        end
        return mask;
    endfunction

endpackage

### sv/lz77td_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies; holds the history window of the lz77 token decoder
module lz77td_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32768
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // read port, data holds while re is low
    always_ff @(posedge clk) begin
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/lz77_token_decoder_top.sv
// lz77 token decoder: 32 KiB history window, literal and match expansion
// depends on lz77td_pkg, lz77td_ram and lz77_token_decoder_top_defines.svh
//
// Usage: each beat on the s_ channel is one decoded token (literal, length/
// distance pair or end of block). Each beat on the m_ channel carries up to
// eight bytes; m_tlast marks the final beat of a token and m_tuser marks the
// end-of-block beat. After end of block every further token answers with the
// end-of-block beat until reset.
// Sequence: a literal or end-of-block token is accepted in the idle state, its
// beat is valid the cycle after acceptance. A match of length L passes a setup
// state that forms the start address, then a read state and a write state per
// byte on the window ram. An unused symbol is accepted and gives no beat.
// Reset: aresetn (synchronous, low) clears the write position and the end
// flag. A wrap flag and the write position mark which window positions were
// written; reads of positions never written return zero, so no ram sweep is
// needed and the block is ready as soon as reset is released.
// Stall: a single output register holds each beat; while it is full and
// m_tready is low, s_tready stays low and a match pauses before the byte
// that would complete the next beat.
`include "lz77_token_decoder_top_defines.svh"

module lz77_token_decoder_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // symbol[8:0], length_extra[13:9], distance_code[18:14], distance_extra[31:19]
    input  logic [31:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_bytes[63:0], byte_count[67:64], zero fill [71:68]
    output logic [71:0] m_tdata,
    output logic        m_tlast,
    // end_of_block[0]
    output logic [0:0]  m_tuser
);

    // field unpacking
    logic [lz77td_pkg::SYM_W-1:0] sym;
    logic [lz77td_pkg::LX_W-1:0]  lx;
    logic [lz77td_pkg::DC_W-1:0]  dc;
    logic [lz77td_pkg::DX_W-1:0]  dx;

    assign sym = s_tdata[8:0];
    assign lx  = s_tdata[13:9];
    assign dc  = s_tdata[18:14];
    assign dx  = s_tdata[31:19];

    // control state
    lz77td_pkg::state_t state_reg, state_next;
    logic                          ended_reg, ended_next;
    logic                          wrapped_reg, wrapped_next;
    logic [lz77td_pkg::WIN_AW-1:0] wp_reg, wp_next;
    logic                          m_valid_reg, m_valid_next;

    // match datapath
    logic [lz77td_pkg::WIN_AW-1:0] src_reg, src_next;
    logic [lz77td_pkg::WIN_AW-1:0] dpart_reg, dpart_next;
    logic [lz77td_pkg::LEN_W-1:0]  rem_reg, rem_next;
    logic [lz77td_pkg::BPR_AW-1:0] n_reg, n_next;
    logic [lz77td_pkg::OUT_W-1:0]  acc_reg, acc_next;
    logic                          rvalid_reg, rvalid_next;

    // output register payload
    logic [lz77td_pkg::OUT_W-1:0]  bytes_reg, bytes_next;
    logic [lz77td_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic                          last_reg, last_next;
    logic                          eob_reg, eob_next;

    // ram port
    logic                          ram_we;
    logic [lz77td_pkg::WIN_AW-1:0] ram_waddr;
    logic [lz77td_pkg::BYTE_W-1:0] ram_wdata;
    logic                          ram_re;
    logic [lz77td_pkg::BYTE_W-1:0] ram_rdata;

    // handshake helpers
    logic                          out_free;
    logic                          s_fire;
    logic                          tok_eob;
    logic                          tok_lit;
    logic                          tok_match;
    logic                          group_done;
    logic                          can_write;
    logic                          out_load;
    logic [lz77td_pkg::BYTE_W-1:0] cur_byte;
    logic [lz77td_pkg::OUT_W-1:0]  acc_with;
    logic [lz77td_pkg::LEN_W-1:0]  match_len;

    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == lz77td_pkg::ST_IDLE) && out_free;
    assign s_fire    = s_tvalid && s_tready;
    assign tok_eob   = ended_reg || (sym == lz77td_pkg::SYM_EOB);
    assign tok_lit   = !tok_eob && (sym < lz77td_pkg::SYM_LIT_LIMIT);
    assign tok_match = !tok_eob && !tok_lit && (sym < lz77td_pkg::SYM_EOB);

    // match length from the length code table
    assign match_len = lz77td_pkg::LEN_W'(lz77td_pkg::len_base(sym[4:0]))
                     + lz77td_pkg::LEN_W'(lx & lz77td_pkg::len_mask(sym[4:0]))
                     + lz77td_pkg::MIN_MATCH;

    // byte coming back from the window, zero where never written
    assign cur_byte   = rvalid_reg ? ram_rdata : '0;
    assign group_done = (n_reg == lz77td_pkg::BPR_AW'(lz77td_pkg::BPR - 1))
                     || (rem_reg == lz77td_pkg::LEN_W'(1));
    assign can_write  = !group_done || out_free;

    always_comb begin
        acc_with = acc_reg;
        acc_with[{n_reg, 3'b000} +: lz77td_pkg::BYTE_W] = cur_byte;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lz77td_pkg::ST_IDLE: begin
                if (s_fire && tok_match) begin
                    state_next = lz77td_pkg::ST_SETUP;
                end
            end
            lz77td_pkg::ST_SETUP: begin
                state_next = lz77td_pkg::ST_READ;
            end
            lz77td_pkg::ST_READ: begin
                state_next = lz77td_pkg::ST_WRITE;
            end
            lz77td_pkg::ST_WRITE: begin
                if (can_write) begin
                    state_next = (rem_reg == lz77td_pkg::LEN_W'(1)) ?
                                 lz77td_pkg::ST_IDLE : lz77td_pkg::ST_READ;
                end
            end
            default: begin
                state_next = lz77td_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and outputs per state
    always_comb begin
        ended_next   = ended_reg;
        wrapped_next = wrapped_reg;
        wp_next      = wp_reg;
        src_next     = src_reg;
        dpart_next   = dpart_reg;
        rem_next     = rem_reg;
        n_next       = n_reg;
        acc_next     = acc_reg;
        rvalid_next  = rvalid_reg;
        bytes_next   = bytes_reg;
        cnt_next     = cnt_reg;
        last_next    = last_reg;
        eob_next     = eob_reg;
        ram_we       = 1'b0;
        ram_waddr    = wp_reg;
        ram_wdata    = cur_byte;
        ram_re       = 1'b0;
        out_load     = 1'b0;
        case (state_reg)
            lz77td_pkg::ST_IDLE: begin
                if (s_fire) begin
                    if (tok_eob) begin
                        ended_next = 1'b1;
                        out_load   = 1'b1;
                        bytes_next = '0;
                        cnt_next   = '0;
                        last_next  = 1'b1;
                        eob_next   = 1'b1;
                    end else if (tok_lit) begin
                        ram_we       = 1'b1;
                        ram_wdata    = sym[7:0];
                        wp_next      = wp_reg + 1'b1;
                        wrapped_next = wrapped_reg || (&wp_reg);
                        out_load     = 1'b1;
                        bytes_next   = lz77td_pkg::OUT_W'(sym[7:0]);
                        cnt_next     = lz77td_pkg::CNT_W'(1);
                        last_next    = 1'b1;
                        eob_next     = 1'b0;
                    end else if (tok_match) begin
                        rem_next   = match_len;
                        dpart_next = lz77td_pkg::dist_base(dc)
                                   + lz77td_pkg::WIN_AW'(dx & lz77td_pkg::dist_mask(dc));
                        n_next     = '0;
                        acc_next   = '0;
                    end
                end
            end
            lz77td_pkg::ST_SETUP: begin
                // start of copy, modulo the window
                src_next = wp_reg - dpart_reg - lz77td_pkg::WIN_AW'(rem_reg);
            end
            lz77td_pkg::ST_READ: begin
                ram_re      = 1'b1;
                rvalid_next = wrapped_reg || (src_reg < wp_reg);
            end
            lz77td_pkg::ST_WRITE: begin
                if (can_write) begin
                    ram_we       = 1'b1;
                    wp_next      = wp_reg + 1'b1;
                    wrapped_next = wrapped_reg || (&wp_reg);
                    src_next     = src_reg + 1'b1;
                    rem_next     = rem_reg - 1'b1;
                    if (group_done) begin
                        out_load   = 1'b1;
                        bytes_next = acc_with;
                        cnt_next   = lz77td_pkg::CNT_W'(n_reg) + 1'b1;
                        last_next  = (rem_reg == lz77td_pkg::LEN_W'(1));
                        eob_next   = 1'b0;
                        n_next     = '0;
                        acc_next   = '0;
                    end else begin
                        n_next   = n_reg + 1'b1;
                        acc_next = acc_with;
                    end
                end
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
        // output register valid
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= lz77td_pkg::ST_IDLE;
            ended_reg   <= 1'b0;
            wrapped_reg <= 1'b0;
            wp_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ended_reg   <= ended_next;
            wrapped_reg <= wrapped_next;
            wp_reg      <= wp_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        src_reg    <= src_next;
        dpart_reg  <= dpart_next;
        rem_reg    <= rem_next;
        n_reg      <= n_next;
        acc_reg    <= acc_next;
        rvalid_reg <= rvalid_next;
        bytes_reg  <= bytes_next;
        cnt_reg    <= cnt_next;
        last_reg   <= last_next;
        eob_reg    <= eob_next;
    end

    // history window
    lz77td_ram #(
        .WIDTH(lz77td_pkg::BYTE_W),
        .DEPTH(lz77td_pkg::WIN_DEPTH)
    ) u_window (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (src_reg),
        .rdata (ram_rdata)
    );

    // result channel
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, cnt_reg, bytes_reg};
    assign m_tlast  = last_reg;
    assign m_tuser  = eob_reg;

    // checks
    `LZTD_NEVER(a_no_overwrite, out_load && !out_free, "result register overwritten")
    `LZTD_ASSERT(a_eob_beat, m_valid_reg && eob_reg |-> (cnt_reg == '0) && last_reg, "bad eob beat")
    `LZTD_ASSERT(a_data_cnt, m_valid_reg && !eob_reg |-> (cnt_reg != '0) && (cnt_reg <= lz77td_pkg::CNT_W'(lz77td_pkg::BPR)), "bad byte count")
    `LZTD_ASSERT(a_ended_sticky, ended_reg |=> ended_reg, "end flag cleared")
    `LZTD_ASSERT(a_wp_step, ram_we |=> (wp_reg == $past(wp_reg) + 1'b1), "write position skipped")

endmodule

### verif/lz77_token_decoder_top_tb.sv
// self-checking testbench for lz77_token_decoder_top: literal, match, end-of-block tokens
// keeps its own copy of the 32 KiB history window and predicts every m_ beat
// depends on lz77td_pkg and the decoder rtl only
module lz77_token_decoder_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lz77td_pkg::*;

    // worst run: ~520 tokens, each a longest match of 33 beats under stalls, with a margin of x4
    localparam int unsigned CYCLE_LIMIT  = 1_500_000;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned HOLD_CYCLES  = 400;

    typedef struct {
        logic [SYM_W-1:0] symbol;
        logic [LX_W-1:0]  len_extra;
        logic [DC_W-1:0]  dist_code;
        logic [DX_W-1:0]  dist_extra;
    } token_t;

    typedef struct {
        logic [OUT_W-1:0] out_bytes;
        logic [CNT_W-1:0] byte_count;
        logic             last_of_token;
        logic             end_of_block;
    } beat_t;

    // deflate length and distance tables
    int unsigned len_base_tab [28] = '{
        0, 1, 2, 3, 4, 5, 6, 7, 8, 10, 12, 14, 16, 20,
        24, 28, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224};
    int unsigned len_xbits_tab [28] = '{
        0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 1, 1, 2, 2,
        2, 2, 3, 3, 3, 3, 4, 4, 4, 4, 5, 5, 5, 5};
    int unsigned dist_base_tab [30] = '{
        0, 1, 2, 3, 4, 6, 8, 12, 16, 24, 32, 48, 64, 96, 128,
        192, 256, 384, 512, 768, 1024, 1536, 2048, 3072, 4096, 6144,
        8192, 12288, 16384, 24576};
    int unsigned dist_xbits_tab [30] = '{
        0, 0, 0, 0, 1, 1, 2, 2, 3, 3, 4, 4, 5, 5, 6,
        6, 7, 7, 8, 8, 9, 9, 10, 10, 11, 11, 12, 12, 13, 13};

    logic             aclk     = 1'b0;
    logic             aresetn  = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [31:0]      s_tdata  = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [71:0]      m_tdata;
    logic             m_tlast;
    logic [0:0]       m_tuser;

    // predicted decoder state
    bit   [7:0]        history_copy [WIN_DEPTH];
    bit   [WIN_AW-1:0] write_pos;
    bit                stream_closed;
    beat_t             expected_beats [$];

    // run control and statistics
    bit          idle_on = 1'b1;
    int unsigned hold_left;
    int unsigned stall_left;
    int unsigned cycle_count;
    int unsigned err_count;
    int unsigned beats_checked;
    int unsigned literal_count;
    int unsigned match_count;
    int unsigned ignored_count;
    int unsigned eob_count;
    int unsigned bytes_copied;

    lz77_token_decoder_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** lz77_token_decoder_top: FAILED **");
            $finish;
        end
    end

    // receiver: long hold when asked, otherwise short random stall bursts while idling is on
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 5) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // compare each output beat with the oldest prediction
    always @(posedge aclk) begin : beat_checker
        beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            beats_checked = beats_checked + 1;
            if (expected_beats.size() == 0) begin
                $error("unexpected beat: data %h last %b user %b", m_tdata, m_tlast, m_tuser);
                err_count = err_count + 1;
            end else begin
                want = expected_beats.pop_front();
                if (m_tdata[63:0] !== want.out_bytes) begin
                    $error("out_bytes: expected %h, got %h", want.out_bytes, m_tdata[63:0]);
                    err_count = err_count + 1;
                end
                if (m_tdata[67:64] !== want.byte_count) begin
                    $error("byte_count: expected %0d, got %0d", want.byte_count,
                           m_tdata[67:64]);
                    err_count = err_count + 1;
                end
                if (m_tlast !== want.last_of_token) begin
                    $error("last_of_token: expected %b, got %b", want.last_of_token, m_tlast);
                    err_count = err_count + 1;
                end
                if (m_tuser[0] !== want.end_of_block) begin
                    $error("end_of_block: expected %b, got %b", want.end_of_block, m_tuser[0]);
                    err_count = err_count + 1;
                end
            end
        end
    end

    // expected beats for one accepted token; updates the window copy
    function automatic void predict_token(input token_t t);
        int unsigned code;
        int unsigned dcode;
        int unsigned run_len;
        int unsigned back_dist;
        int unsigned n;
        logic [WIN_AW-1:0] src;
        logic [7:0]        b;
        beat_t             r;
        if (stream_closed || t.symbol == SYM_EOB) begin
            stream_closed = 1'b1;
            eob_count = eob_count + 1;
            expected_beats.push_back('{out_bytes: '0, byte_count: '0,
                                       last_of_token: 1'b1, end_of_block: 1'b1});
            return;
        end
        if (t.symbol > SYM_EOB) begin
            ignored_count = ignored_count + 1;
            return;
        end
        if (t.symbol < SYM_LIT_LIMIT) begin
            literal_count = literal_count + 1;
            history_copy[write_pos] = t.symbol[7:0];
            write_pos = write_pos + 1'b1;
            expected_beats.push_back('{out_bytes: OUT_W'(t.symbol[7:0]), byte_count: 4'd1,
                                       last_of_token: 1'b1, end_of_block: 1'b0});
            return;
        end
        match_count = match_count + 1;
        code    = t.symbol - SYM_LIT_LIMIT;
        run_len = len_base_tab[code] + (t.len_extra & ((1 << len_xbits_tab[code]) - 1))
                  + MIN_MATCH;
        // codes 30 and 31 fall back to the last distance code
        dcode = (t.dist_code > DIST_CODE_MAX) ? DIST_CODE_MAX : t.dist_code;
        back_dist = dist_base_tab[dcode]
                    + (t.dist_extra & ((1 << dist_xbits_tab[dcode]) - 1)) + run_len;
        src   = write_pos - WIN_AW'(back_dist);
        r     = '{out_bytes: '0, byte_count: '0, last_of_token: 1'b0, end_of_block: 1'b0};
        n     = 0;
        // byte-serial copy so overlapping sources repeat fresh output
        for (int i = 0; i < run_len; i++) begin
            b = history_copy[src];
            src = src + 1'b1;
            history_copy[write_pos] = b;
            write_pos = write_pos + 1'b1;
            r.out_bytes[8*n +: 8] = b;
            n = n + 1;
            if (n == BPR || i + 1 == run_len) begin
                r.byte_count    = CNT_W'(n);
                r.last_of_token = (i + 1 == run_len);
                expected_beats.push_back(r);
                r = '{out_bytes: '0, byte_count: '0, last_of_token: 1'b0, end_of_block: 1'b0};
                n = 0;
            end
        end
        bytes_copied = bytes_copied + run_len;
    endfunction

    function automatic token_t mk_token(input int unsigned sym, input int unsigned lx,
                                        input int unsigned dc, input int unsigned dx);
        token_t t;
        t.symbol     = SYM_W'(sym);
        t.len_extra  = LX_W'(lx);
        t.dist_code  = DC_W'(dc);
        t.dist_extra = DX_W'(dx);
        return t;
    endfunction

    // mostly literals and short matches, some long matches and unused symbols
    function automatic token_t random_token();
        token_t      t;
        int unsigned pick;
        t.len_extra  = LX_W'($urandom);
        t.dist_code  = ($urandom_range(0, 1) == 0) ? DC_W'($urandom)
                                                   : DC_W'($urandom_range(0, 9));
        t.dist_extra = DX_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 42) begin
            t.symbol = SYM_W'($urandom_range(0, 255));
        end else if (pick < 92) begin
            if ($urandom_range(0, 4) != 0) begin
                t.symbol = SYM_LIT_LIMIT + SYM_W'($urandom_range(0, 15));
            end else begin
                t.symbol = SYM_LIT_LIMIT + SYM_W'($urandom_range(16, LEN_CODE_MAX));
            end
        end else begin
            t.symbol = SYM_W'($urandom_range(SYM_EOB + 1, (1 << SYM_W) - 1));
        end
        return t;
    endfunction

    // offer one token on the s_ channel and predict it once accepted
    task automatic send_token(input token_t t);
        @(negedge aclk);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge aclk);
        end
        // distance_extra, distance_code, length_extra, symbol from msb down
        s_tdata  <= {t.dist_extra, t.dist_code, t.len_extra, t.symbol};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_token(t);
    endtask

    // drop valid and let every predicted beat come out
    task automatic wait_quiet();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // field extremes, every length class, wrap and clamp cases, unused symbols
    task automatic test_directed_tokens();
        send_token(mk_token(0, 0, 0, 0));
        send_token(mk_token(255, 31, 31, 13'h1fff));
        send_token(mk_token(8'h5a, 0, 0, 0));
        send_token(mk_token(8'ha5, 0, 0, 0));
        send_token(mk_token(8'h3c, 0, 0, 0));
        send_token(mk_token(8'hc3, 0, 0, 0));
        // shortest match over the last three literals
        send_token(mk_token(SYM_LIT_LIMIT, 0, 0, 0));
        // exactly one full beat
        send_token(mk_token(SYM_LIT_LIMIT + 5, 0, 0, 0));
        // excess length and distance extra bits
        send_token(mk_token(SYM_LIT_LIMIT + 13, 31, 4, 13'h1fff));
        // longest match reaching back past position zero
        send_token(mk_token(SYM_LIT_LIMIT + LEN_CODE_MAX, 31, 0, 0));
        // distance beyond the window
        send_token(mk_token(SYM_LIT_LIMIT + 24, 0, DIST_CODE_MAX, 13'h1fff));
        // distance codes above the table
        send_token(mk_token(SYM_LIT_LIMIT + 8, 1, 30, 13'h1fff));
        send_token(mk_token(SYM_LIT_LIMIT + 8, 1, 31, 0));
        // unused symbols
        send_token(mk_token(SYM_EOB + 1, 31, 31, 13'h1fff));
        send_token(mk_token((1 << SYM_W) - 1, 0, 0, 0));
        send_token(mk_token(SYM_LIT_LIMIT + 20, 15, 10, 7));
        send_token(mk_token(SYM_LIT_LIMIT + 16, 7, 16, 127));
        send_token(mk_token(8'h81, 0, 0, 0));
        send_token(mk_token(SYM_LIT_LIMIT + 1, 0, 1, 0));
        send_token(mk_token(SYM_LIT_LIMIT + 12, 2, 3, 1));
        wait_quiet();
    endtask

    // receiver holds off while tokens keep coming, so the decoder backs up
    task automatic test_output_backpressure();
        idle_on   = 1'b0;
        hold_left = HOLD_CYCLES;
        repeat (30) send_token(random_token());
        wait_quiet();
        idle_on = 1'b1;
    endtask

    task automatic test_random_tokens(input int unsigned n_items);
        token_t      t;
        int unsigned sent;
        sent = 0;
        while (sent < n_items) begin
            t = random_token();
            send_token(t);
            if (t.symbol <= SYM_EOB) sent = sent + 1;
        end
        wait_quiet();
    endtask

    // end of block, then every later token answers with end of block
    task automatic test_end_of_block();
        send_token(mk_token(8'h11, 0, 0, 0));
        send_token(mk_token(SYM_LIT_LIMIT + 2, 0, 2, 0));
        send_token(mk_token(SYM_EOB, 0, 0, 0));
        send_token(mk_token(8'h22, 0, 0, 0));
        send_token(mk_token(SYM_LIT_LIMIT + LEN_CODE_MAX, 31, 0, 0));
        send_token(mk_token(SYM_EOB + 1, 0, 0, 0));
        send_token(mk_token(SYM_EOB, 0, 0, 0));
        wait_quiet();
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_tokens();
        test_output_backpressure();
        test_random_tokens(310);
        // no idling from here to the end
        idle_on = 1'b0;
        test_random_tokens(80);
        test_end_of_block();

        $display("covered: %0d literals, %0d matches (%0d bytes copied), %0d unused symbols",
                 literal_count, match_count, bytes_copied, ignored_count);
        $display("covered: %0d end-of-block answers, %0d beats checked, %0d mismatches",
                 eob_count, beats_checked, err_count);
        if (err_count == 0) begin
            $display("** lz77_token_decoder_top: PASSED **");
        end else begin
            $display("** lz77_token_decoder_top: FAILED **");
        end
        $finish;
    end

endmodule

### lz77_token_decoder_top.f
+incdir+sv
sv/lz77td_pkg.sv
sv/lz77td_ram.sv
sv/lz77_token_decoder_top.sv
verif/lz77_token_decoder_top_tb.sv
